### src/lrbd_pkg.sv
// Shared sizes, types and the arctangent table for the relative bearing and distance block.
package lrbd_pkg;

  localparam int COORD_BITS = 10;
  localparam int FRAC_BITS  = 16;

  localparam int COORD_IN_W = 10;
  localparam int CH_W       = 8;
  localparam int ANGLE_W    = 9;
  localparam int LEVEL_W    = 8;
  localparam int MAXD_W     = 8;
  localparam logic [MAXD_W-1:0] MAXD_RESET = MAXD_W'(10);

  localparam int D_W   = COORD_BITS + 1;
  localparam int P_W   = COORD_BITS + 3;
  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int D2_W  = SQ_W + 1;

  // 255 * 255 = 2^16 - 2^9 + 1
  localparam int LVL_SH_HI = 16;
  localparam int LVL_SH_LO = 9;

  localparam int RAD_MIN_W  = D2_W + LVL_SH_HI;
  localparam int SQRT_STEPS = (RAD_MIN_W + 1) / 2;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int SREM_W     = SQRT_STEPS + 2;

  localparam int DIV_STEPS = LEVEL_W;
  localparam int DK_W      = $clog2(DIV_STEPS);
  localparam int DV_W      = (SQRT_STEPS > MAXD_W + DIV_STEPS) ? SQRT_STEPS
                                                               : MAXD_W + DIV_STEPS;

  localparam int ATAN_STEPS = 24;
  localparam int ATAN_IDX_W = $clog2(ATAN_STEPS);
  localparam int N_CELLS    = (ATAN_STEPS > SQRT_STEPS + DIV_STEPS) ? ATAN_STEPS
                                                                    : SQRT_STEPS + DIV_STEPS;
  localparam int STEP_W     = $clog2(N_CELLS + 1);

  localparam int X_W = COORD_BITS + FRAC_BITS + 5;
  localparam int Z_W = FRAC_BITS + 9;

  localparam int QUAD_W     = 7;
  localparam int QUAD_MAX   = 89;
  localparam int DIAG_DEG   = 45;
  localparam int ANGLE_FULL = 360;
  localparam int BASE_RIGHT  = 90;
  localparam int BASE_BEHIND = 180;
  localparam int BASE_LEFT   = 270;

  localparam int TBL_FRAC = 24;
  localparam logic [32:0] ATAN_HALF = (TBL_FRAC > FRAC_BITS) ?
                                      33'(1) << (TBL_FRAC - 1 - FRAC_BITS) : 33'(0);

  localparam logic [31:0] ATAN_Q24 [ATAN_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  typedef enum logic [1:0] {
    QUAD_AHEAD,
    QUAD_RIGHT,
    QUAD_BEHIND,
    QUAD_LEFT
  } quad_e;

  typedef struct packed {
    logic [CH_W-1:0]         channel;
    logic                    nz;
    quad_e                   quad;
    logic                    ysz;
    logic                    diag;
    logic signed [X_W-1:0]   x;
    logic signed [X_W-1:0]   y;
    logic signed [Z_W-1:0]   z;
    logic [RAD_W-1:0]        rad;
    logic [SQRT_STEPS-1:0]   root;
    logic [SREM_W-1:0]       srem;
    logic [DV_W-1:0]         drem;
    logic [LEVEL_W-1:0]      quo;
    logic                    clamp;
    logic                    rzero;
  } item_t;

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic [ANGLE_W-1:0] angle;
    logic [LEVEL_W-1:0] level;
  } res_t;

  function automatic logic signed [Z_W-1:0] atan_step(input logic [ATAN_IDX_W-1:0] idx);
    logic [32:0] sum;
    sum = 33'(ATAN_Q24[idx]) + ATAN_HALF;
    return Z_W'(sum >> (TBL_FRAC - FRAC_BITS));
  endfunction

endpackage

### src/lrbd_prep.sv
// Front stages: offsets, projections, squared distance and quadrant fold.
module lrbd_prep import lrbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  vld_i,
  input  logic [CH_W-1:0]       channel_i,
  input  logic [COORD_IN_W-1:0] lis_col_i,
  input  logic [COORD_IN_W-1:0] lis_row_i,
  input  logic [COORD_IN_W-1:0] src_col_i,
  input  logic [COORD_IN_W-1:0] src_row_i,
  input  logic signed [1:0]     fx_i,
  input  logic signed [1:0]     fy_i,
  output logic                  vld_o,
  output item_t                 item_o
);

  logic signed [D_W-1:0]     dx, dy;
  logic signed [2*D_W-1:0]   sqx, sqy;
  logic signed [P_W-1:0]     f, r;

  logic                      vld1_q;
  logic [CH_W-1:0]           ch1_q;
  logic [SQ_W-1:0]           dx2_q, dy2_q;
  logic signed [P_W-1:0]     f1_q, r1_q;

  logic [D2_W-1:0]           d2;
  logic [RAD_W-1:0]          rad;
  logic signed [P_W-1:0]     xq, yq;
  quad_e                     quad;
  item_t                     item_d, item_q;
  logic                      vld2_q;

  assign dx = $signed({1'b0, COORD_BITS'(src_col_i)}) - $signed({1'b0, COORD_BITS'(lis_col_i)});
  assign dy = $signed({1'b0, COORD_BITS'(src_row_i)}) - $signed({1'b0, COORD_BITS'(lis_row_i)});
  assign sqx = (2*D_W)'(dx) * (2*D_W)'(dx);
  assign sqy = (2*D_W)'(dy) * (2*D_W)'(dy);
  assign f = P_W'(fx_i) * P_W'(dx) + P_W'(fy_i) * P_W'(dy);
  assign r = P_W'(fx_i) * P_W'(dy) - P_W'(fy_i) * P_W'(dx);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
      vld2_q <= 1'b0;
    end else if (adv_i) begin
      vld1_q <= vld_i;
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      ch1_q  <= channel_i;
      dx2_q  <= sqx[SQ_W-1:0];
      dy2_q  <= sqy[SQ_W-1:0];
      f1_q   <= f;
      r1_q   <= r;
      item_q <= item_d;
    end
  end

  assign d2  = D2_W'(dx2_q) + D2_W'(dy2_q);
  assign rad = (RAD_W'(d2) << LVL_SH_HI) - (RAD_W'(d2) << LVL_SH_LO) + RAD_W'(d2);

  always_comb begin
    if (f1_q > 0 && r1_q >= 0) begin
      quad = QUAD_AHEAD;
      xq   = f1_q;
      yq   = r1_q;
    end else if (f1_q <= 0 && r1_q > 0) begin
      quad = QUAD_RIGHT;
      xq   = r1_q;
      yq   = -f1_q;
    end else if (f1_q < 0 && r1_q <= 0) begin
      quad = QUAD_BEHIND;
      xq   = -f1_q;
      yq   = -r1_q;
    end else begin
      quad = QUAD_LEFT;
      xq   = -r1_q;
      yq   = f1_q;
    end
  end

  always_comb begin
    item_d         = '0;
    item_d.channel = ch1_q;
    item_d.nz      = (f1_q != '0) || (r1_q != '0);
    item_d.quad    = quad;
    item_d.ysz     = yq == '0;
    item_d.diag    = yq == xq;
    item_d.x       = X_W'(xq) <<< FRAC_BITS;
    item_d.y       = X_W'(yq) <<< FRAC_BITS;
    item_d.rad     = rad;
  end

  assign vld_o  = vld2_q;
  assign item_o = item_q;

endmodule

### src/lrbd_cell.sv
// A chain cell: CORDIC rotation, root digit, quotient bit, each for its step range.
module lrbd_cell import lrbd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              adv_i,
  input  logic [STEP_W-1:0] step_i,
  input  logic [MAXD_W-1:0] max_i,
  input  logic              vld_i,
  input  item_t             item_i,
  output logic              vld_o,
  output item_t             item_o
);

  logic signed [X_W-1:0] xs, ys;
  logic [SREM_W-1:0]     rem_sh, trial;
  logic [DV_W-1:0]       drem_in, dv;
  logic [DK_W-1:0]       k;
  logic                  first_div;
  item_t                 item_d, item_q;
  logic                  vld_q;

  always_comb begin
    item_d    = item_i;
    xs        = $signed(item_i.x) >>> step_i;
    ys        = $signed(item_i.y) >>> step_i;
    rem_sh    = {item_i.srem[SQRT_STEPS-1:0], item_i.rad[RAD_W-1 -: 2]};
    trial     = {item_i.root, 2'b01};
    first_div = step_i == STEP_W'(SQRT_STEPS);
    drem_in   = first_div ? DV_W'(item_i.root) : item_i.drem;
    k         = DK_W'(STEP_W'(SQRT_STEPS + DIV_STEPS - 1) - step_i);
    dv        = DV_W'(max_i) << k;

    if (step_i < STEP_W'(ATAN_STEPS)) begin
      if (!item_i.y[X_W-1]) begin
        item_d.x = item_i.x + ys;
        item_d.y = item_i.y - xs;
        item_d.z = item_i.z + atan_step(step_i[ATAN_IDX_W-1:0]);
      end else begin
        item_d.x = item_i.x - ys;
        item_d.y = item_i.y + xs;
        item_d.z = item_i.z - atan_step(step_i[ATAN_IDX_W-1:0]);
      end
    end

    if (step_i < STEP_W'(SQRT_STEPS)) begin
      item_d.rad = item_i.rad << 2;
      if (rem_sh >= trial) begin
        item_d.srem = rem_sh - trial;
        item_d.root = {item_i.root[SQRT_STEPS-2:0], 1'b1};
      end else begin
        item_d.srem = rem_sh;
        item_d.root = {item_i.root[SQRT_STEPS-2:0], 1'b0};
      end
    end

    if (step_i >= STEP_W'(SQRT_STEPS) && step_i < STEP_W'(SQRT_STEPS + DIV_STEPS)) begin
      if (first_div) begin
        item_d.clamp = DV_W'(item_i.root) >= (DV_W'(max_i) << DIV_STEPS);
        item_d.rzero = item_i.root == '0;
      end
      if (drem_in >= dv) begin
        item_d.drem = drem_in - dv;
        item_d.quo  = {item_i.quo[LEVEL_W-2:0], 1'b1};
      end else begin
        item_d.drem = drem_in;
        item_d.quo  = {item_i.quo[LEVEL_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      item_q <= item_d;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

### src/lrbd_out.sv
// Final angle and level, output register and skid register.
module lrbd_out import lrbd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  item_t              item_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic               skid_full_o,
  output res_t               res_o
);

  logic signed [Z_W-1:0] zsh;
  logic [QUAD_W-1:0]     zdeg, qdeg;
  logic [ANGLE_W-1:0]    base;
  res_t                  res;
  res_t                  out_q, skid_q;
  logic                  out_vld_q, skid_vld_q;
  logic                  take;

  always_comb begin
    zsh = item_i.z >>> FRAC_BITS;
    if (item_i.z[Z_W-1]) begin
      zdeg = '0;
    end else if (zsh > Z_W'(QUAD_MAX)) begin
      zdeg = QUAD_W'(QUAD_MAX);
    end else begin
      zdeg = zsh[QUAD_W-1:0];
    end

    if (item_i.ysz) begin
      qdeg = '0;
    end else if (item_i.diag) begin
      qdeg = QUAD_W'(DIAG_DEG);
    end else begin
      qdeg = zdeg;
    end

    unique case (item_i.quad)
      QUAD_AHEAD:  base = '0;
      QUAD_RIGHT:  base = ANGLE_W'(BASE_RIGHT);
      QUAD_BEHIND: base = ANGLE_W'(BASE_BEHIND);
      QUAD_LEFT:   base = ANGLE_W'(BASE_LEFT);
      default:     base = '0;
    endcase

    res.channel = item_i.channel;
    res.angle   = item_i.nz ? base + ANGLE_W'(qdeg) : '0;
    if (item_i.rzero) begin
      res.level = '0;
    end else if (item_i.clamp) begin
      res.level = '1;
    end else begin
      res.level = item_i.quo;
    end
  end

  assign take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (vld_i) begin
      if (!out_vld_q || take) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (take) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (vld_i) begin
      if (!out_vld_q || take) begin
        out_q <= res;
      end else begin
        skid_q <= res;
      end
    end
  end

  assign out_valid_o = out_vld_q;
  assign skid_full_o = skid_vld_q;
  assign res_o       = out_q;

endmodule

### src/listener_relative_bearing_distance.sv
// Top level: relative bearing and scaled distance of a sound source, one transaction per cycle unless stalled.
// Path from input transaction to out_valid_o:
//   two set-up stages, N_CELLS chain cells (CORDIC steps beside root digits and quotient bits), output reg.
// Throughput: one transaction per cycle while in_stall_o is low; a skid register absorbs one result under stall.
// Reset: clears all valid flags and sets max_distance_cells to 10.
// Non-playing transactions are taken and produce no result.
module listener_relative_bearing_distance import lrbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CH_W-1:0]       channel_id_i,
  input  logic                  channel_playing_i,
  input  logic [COORD_IN_W-1:0] listener_col_i,
  input  logic [COORD_IN_W-1:0] listener_row_i,
  input  logic [COORD_IN_W-1:0] source_col_i,
  input  logic [COORD_IN_W-1:0] source_row_i,
  input  logic signed [1:0]     facing_x_i,
  input  logic signed [1:0]     facing_y_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CH_W-1:0]       channel_out_o,
  output logic [ANGLE_W-1:0]    pan_angle_o,
  output logic [LEVEL_W-1:0]    distance_level_o,
  input  logic                  cfg_we_i,
  input  logic [MAXD_W-1:0]     cfg_wdata_i
);

  logic [MAXD_W-1:0]  max_q;
  logic               adv;
  logic               skid_full;
  logic [N_CELLS:0]   cell_vld;
  item_t              cell_item [N_CELLS+1];
  res_t               res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MAXD_RESET;
    end else if (cfg_we_i) begin
      max_q <= cfg_wdata_i;
    end
  end

  assign adv        = !skid_full;
  assign in_stall_o = skid_full;

  lrbd_prep u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .adv_i     (adv),
    .vld_i     (in_valid_i & channel_playing_i),
    .channel_i (channel_id_i),
    .lis_col_i (listener_col_i),
    .lis_row_i (listener_row_i),
    .src_col_i (source_col_i),
    .src_row_i (source_row_i),
    .fx_i      (facing_x_i),
    .fy_i      (facing_y_i),
    .vld_o     (cell_vld[0]),
    .item_o    (cell_item[0])
  );

  for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
    lrbd_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .adv_i  (adv),
      .step_i (STEP_W'(i)),
      .max_i  (max_q),
      .vld_i  (cell_vld[i]),
      .item_i (cell_item[i]),
      .vld_o  (cell_vld[i+1]),
      .item_o (cell_item[i+1])
    );
  end

  lrbd_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .vld_i       (cell_vld[N_CELLS]),
    .item_i      (cell_item[N_CELLS]),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .skid_full_o (skid_full),
    .res_o       (res)
  );

  assign channel_out_o    = res.channel;
  assign pan_angle_o      = res.angle;
  assign distance_level_o = res.level;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_full |-> out_valid_o)
    else $error("skid register holds a result while the output register is empty");

  a_chain_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(cell_vld))
    else $error("chain moved while frozen");

  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pan_angle_o < ANGLE_W'(ANGLE_FULL))
    else $error("bearing out of range");

endmodule

### bench/bearing_distance_checker.sv
// Checker: predicts bearing and distance for each accepted playing transaction and compares the results.
module bearing_distance_checker import lrbd_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [CH_W-1:0]       channel_id_i,
  input  logic                  channel_playing_i,
  input  logic [COORD_IN_W-1:0] listener_col_i,
  input  logic [COORD_IN_W-1:0] listener_row_i,
  input  logic [COORD_IN_W-1:0] source_col_i,
  input  logic [COORD_IN_W-1:0] source_row_i,
  input  logic signed [1:0]     facing_x_i,
  input  logic signed [1:0]     facing_y_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [CH_W-1:0]       channel_out_i,
  input  logic [ANGLE_W-1:0]    pan_angle_i,
  input  logic [LEVEL_W-1:0]    distance_level_i,
  input  logic                  cfg_we_i,
  input  logic [MAXD_W-1:0]     cfg_wdata_i,
  output int unsigned           fail_count_o,
  output int unsigned           awaited_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC = 16;
  localparam int TBL_FRAC = 24;
  localparam int CORDIC_STEPS = 24;
  localparam longint unsigned TBL_ROUND = 64'd1 << (TBL_FRAC - 1 - FRAC);
  localparam logic [31:0] ATAN_DEG_Q24 [CORDIC_STEPS] = '{
    32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938, 32'd60000934,
    32'd30029717,  32'd15018523,  32'd7509720,   32'd3754917,   32'd1877466,
    32'd938734,    32'd469367,    32'd234684,    32'd117342,    32'd58671,
    32'd29335,     32'd14668,     32'd7334,      32'd3667,      32'd1833,
    32'd917,       32'd458,       32'd229,       32'd115
  };

  typedef struct {
    logic [CH_W-1:0]    channel;
    logic [ANGLE_W-1:0] angle;
    logic [LEVEL_W-1:0] level;
  } bearing_t;

  bearing_t    expected_bearings[$];
  int unsigned max_cells;

  function automatic int unsigned quadrant_angle(longint x0, longint y0);
    longint x, y, z, step, xs, ys;
    int k;
    if (y0 == 0) return 0;
    if (y0 == x0) return 45;
    x = x0 <<< FRAC;
    y = y0 <<< FRAC;
    z = 0;
    for (k = 0; k < CORDIC_STEPS; k++) begin
      step = longint'((longint'(ATAN_DEG_Q24[k]) + TBL_ROUND) >> (TBL_FRAC - FRAC));
      xs = x >>> k;
      ys = y >>> k;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        z = z + step;
      end else begin
        x = x - ys;
        y = y + xs;
        z = z - step;
      end
    end
    if (z < 0) return 0;
    z = z >>> FRAC;
    return (z > 89) ? 89 : int'(z);
  endfunction

  function automatic int unsigned relative_bearing(longint dx, longint dy,
                                                   longint fx, longint fy);
    longint ahead, right;
    ahead = fx * dx + fy * dy;
    right = fx * dy - fy * dx;
    if (ahead == 0 && right == 0) return 0;
    if (ahead > 0 && right >= 0) return quadrant_angle(ahead, right);
    if (ahead <= 0 && right > 0) return 90 + quadrant_angle(right, -ahead);
    if (ahead < 0 && right <= 0) return 180 + quadrant_angle(-ahead, -right);
    return 270 + quadrant_angle(-right, ahead);
  endfunction

  function automatic int unsigned scaled_distance(longint dx, longint dy,
                                                  int unsigned limit);
    longint unsigned sq, rad, root, cand, lvl;
    int b;
    sq = longint'(dx * dx + dy * dy);
    if (limit == 0) return (sq != 0) ? 255 : 0;
    rad = 64'd65025 * sq;
    root = 0;
    for (b = 20; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= rad) root = cand;
    end
    lvl = root / limit;
    return (lvl > 255) ? 255 : int'(lvl);
  endfunction

  task automatic flag_mismatch(input string what);
    if (fail_count_o < 100) $display("mismatch: %s", what);
    fail_count_o++;
  endtask

  always @(posedge clk_i) begin
    bearing_t want;
    longint   dx, dy;
    if (!rst_ni) begin
      max_cells = 10;
      expected_bearings.delete();
      awaited_o = 0;
      fail_count_o = 0;
    end else begin
      if (cfg_we_i === 1'b1) max_cells = cfg_wdata_i;
      if (in_valid_i === 1'b1 && in_stall_i === 1'b0 && channel_playing_i === 1'b1) begin
        dx = longint'(source_col_i) - longint'(listener_col_i);
        dy = longint'(source_row_i) - longint'(listener_row_i);
        want.channel = channel_id_i;
        want.angle = ANGLE_W'(relative_bearing(dx, dy, longint'(facing_x_i),
                                               longint'(facing_y_i)));
        want.level = LEVEL_W'(scaled_distance(dx, dy, max_cells));
        expected_bearings.insert(expected_bearings.size(), want);
      end
      if (out_valid_i === 1'b1 && out_stall_i === 1'b0) begin
        if (expected_bearings.size() == 0) begin
          flag_mismatch($sformatf("result for channel %0d with nothing awaited",
                                  channel_out_i));
        end else begin
          want = expected_bearings.pop_front();
          if (channel_out_i !== want.channel)
            flag_mismatch($sformatf("channel got %0d expected %0d",
                                    channel_out_i, want.channel));
          if (pan_angle_i !== want.angle)
            flag_mismatch($sformatf("channel %0d angle got %0d expected %0d",
                                    want.channel, pan_angle_i, want.angle));
          if (distance_level_i !== want.level)
            flag_mismatch($sformatf("channel %0d level got %0d expected %0d",
                                    want.channel, distance_level_i, want.level));
        end
      end
      awaited_o = expected_bearings.size();
    end
  end

endmodule

### bench/listener_relative_bearing_distance_tb.sv
// Testbench top: drives position transactions and settings into the bearing block, gives the verdict.
module listener_relative_bearing_distance_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import lrbd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_PER_PHASE = 95;
  localparam int HOLD_OFF_AT = 250;
  localparam int HOLD_OFF_CYCLES = 600;

  typedef struct {
    logic [CH_W-1:0]       ch;
    logic                  play;
    logic [COORD_IN_W-1:0] lc;
    logic [COORD_IN_W-1:0] lr;
    logic [COORD_IN_W-1:0] sc;
    logic [COORD_IN_W-1:0] sr;
    logic signed [1:0]     fx;
    logic signed [1:0]     fy;
  } pos_req_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CH_W-1:0]       channel_id = '0;
  logic                  channel_playing = 1'b0;
  logic [COORD_IN_W-1:0] listener_col = '0;
  logic [COORD_IN_W-1:0] listener_row = '0;
  logic [COORD_IN_W-1:0] source_col = '0;
  logic [COORD_IN_W-1:0] source_row = '0;
  logic signed [1:0]     facing_x = '0;
  logic signed [1:0]     facing_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [CH_W-1:0]       channel_out;
  logic [ANGLE_W-1:0]    pan_angle;
  logic [LEVEL_W-1:0]    distance_level;
  logic                  cfg_we = 1'b0;
  logic [MAXD_W-1:0]     cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned items_sent = 0;
  int unsigned results_taken = 0;
  int unsigned cycle_count = 0;
  int unsigned rx_wait = 0;
  bit          tx_quiet = 1'b0;
  bit          rx_quiet = 1'b0;
  logic        hold_off = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  listener_relative_bearing_distance i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .channel_id_i     (channel_id),
    .channel_playing_i(channel_playing),
    .listener_col_i   (listener_col),
    .listener_row_i   (listener_row),
    .source_col_i     (source_col),
    .source_row_i     (source_row),
    .facing_x_i       (facing_x),
    .facing_y_i       (facing_y),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .channel_out_o    (channel_out),
    .pan_angle_o      (pan_angle),
    .distance_level_o (distance_level),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata)
  );

  bearing_distance_checker i_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .channel_id_i     (channel_id),
    .channel_playing_i(channel_playing),
    .listener_col_i   (listener_col),
    .listener_row_i   (listener_row),
    .source_col_i     (source_col),
    .source_row_i     (source_row),
    .facing_x_i       (facing_x),
    .facing_y_i       (facing_y),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .channel_out_i    (channel_out),
    .pan_angle_i      (pan_angle),
    .distance_level_i (distance_level),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .fail_count_o     (fail_count),
    .awaited_o        (awaited)
  );

  function automatic pos_req_t pos_req(int ch, int play, int lc, int lr, int sc, int sr,
                                       int fx, int fy);
    pos_req_t p;
    p.ch = CH_W'(ch);
    p.play = 1'(play);
    p.lc = COORD_IN_W'(lc);
    p.lr = COORD_IN_W'(lr);
    p.sc = COORD_IN_W'(sc);
    p.sr = COORD_IN_W'(sr);
    p.fx = 2'(fx);
    p.fy = 2'(fy);
    return p;
  endfunction

  function automatic logic [COORD_IN_W-1:0] nearby(logic [COORD_IN_W-1:0] c, int reach);
    int v;
    v = int'(c) + int'($urandom_range(0, 2 * reach)) - reach;
    if (v < 0) v = 0;
    else if (v > 1023) v = 1023;
    return COORD_IN_W'(v);
  endfunction

  function automatic pos_req_t random_req();
    pos_req_t p;
    int reach;
    p.ch = CH_W'($urandom);
    p.play = ($urandom_range(0, 7) != 0);
    p.lc = COORD_IN_W'($urandom);
    p.lr = COORD_IN_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      p.sc = COORD_IN_W'($urandom);
      p.sr = COORD_IN_W'($urandom);
    end else begin
      reach = ($urandom_range(0, 1) == 0) ? 3 : 60;
      p.sc = nearby(p.lc, reach);
      p.sr = nearby(p.lr, reach);
    end
    if ($urandom_range(0, 3) == 0) begin
      p.fx = 2'($urandom);
      p.fy = 2'($urandom);
    end else begin
      case ($urandom_range(0, 3))
        0: begin
          p.fx = 2'(1);
          p.fy = 2'(0);
        end
        1: begin
          p.fx = 2'(-1);
          p.fy = 2'(0);
        end
        2: begin
          p.fx = 2'(0);
          p.fy = 2'(1);
        end
        default: begin
          p.fx = 2'(0);
          p.fy = 2'(-1);
        end
      endcase
    end
    return p;
  endfunction

  task automatic offer(input pos_req_t p);
    int gap;
    if (items_sent % 32 == 0) tx_quiet = ($urandom_range(0, 2) == 0);
    gap = tx_quiet ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    channel_id <= p.ch;
    channel_playing <= p.play;
    listener_col <= p.lc;
    listener_row <= p.lr;
    source_col <= p.sc;
    source_row <= p.sr;
    facing_x <= p.fx;
    facing_y <= p.fy;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (awaited == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_max_cells(input logic [MAXD_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random result-side stall, maybe none, after each result; hold off entirely while requested.
  always @(posedge clk) begin
    int unsigned next_wait;
    next_wait = rx_wait;
    if (out_valid === 1'b1 && out_stall === 1'b0) begin
      if (results_taken % 32 == 0) rx_quiet = ($urandom_range(0, 2) == 0);
      results_taken++;
      next_wait = rx_quiet ? 0 : $urandom_range(0, 13);
    end else if (next_wait > 0) begin
      next_wait--;
    end
    rx_wait = next_wait;
    out_stall <= hold_off || (next_wait != 0);
  end

  initial begin
    wait (items_sent >= HOLD_OFF_AT);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    pos_req_t          directed[$];
    logic [MAXD_W-1:0] settings[$];
    directed.insert(directed.size(), pos_req(0,   1, 500, 500, 500, 500, 1, 0));
    directed.insert(directed.size(), pos_req(1,   1, 100, 100, 103, 104, 0, 0));
    directed.insert(directed.size(), pos_req(255, 1, 0, 0, 1023, 1023, 1, 0));
    directed.insert(directed.size(), pos_req(2,   1, 1023, 1023, 0, 0, -1, 0));
    directed.insert(directed.size(), pos_req(3,   1, 0, 1023, 1023, 0, 0, -1));
    directed.insert(directed.size(), pos_req(4,   1, 200, 200, 200, 206, 0, 1));
    directed.insert(directed.size(), pos_req(5,   1, 200, 200, 194, 200, 0, 1));
    directed.insert(directed.size(), pos_req(6,   1, 200, 200, 200, 194, 0, 1));
    directed.insert(directed.size(), pos_req(7,   1, 200, 200, 206, 200, 0, 1));
    directed.insert(directed.size(), pos_req(8,   1, 300, 300, 305, 305, 1, 0));
    directed.insert(directed.size(), pos_req(9,   1, 300, 300, 307, 302, 1, 0));
    directed.insert(directed.size(), pos_req(10,  1, 300, 300, 298, 309, 1, 1));
    directed.insert(directed.size(), pos_req(11,  1, 300, 300, 311, 296, -2, -2));
    directed.insert(directed.size(), pos_req(12,  1, 300, 300, 290, 301, -2, 1));
    directed.insert(directed.size(), pos_req(13,  1, 300, 300, 301, 290, 1, -2));
    directed.insert(directed.size(), pos_req(14,  1, 50, 60, 50, 70, -1, -1));
    directed.insert(directed.size(), pos_req(15,  1, 50, 60, 59, 60, 0, -1));
    directed.insert(directed.size(), pos_req(170, 0, 1023, 1023, 1023, 1023, -1, -1));
    directed.insert(directed.size(), pos_req(85,  0, 0, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), pos_req(16,  1, 0, 0, 0, 0, 0, 0));
    directed.insert(directed.size(), pos_req(17,  1, 1023, 0, 0, 1023, -2, 0));
    directed.insert(directed.size(), pos_req(18,  1, 400, 400, 399, 403, 1, -1));

    settings.insert(settings.size(), MAXD_W'(1));
    settings.insert(settings.size(), MAXD_W'(255));
    settings.insert(settings.size(), MAXD_W'(0));
    settings.insert(settings.size(), MAXD_W'($urandom_range(2, 254)));
    settings.insert(settings.size(), MAXD_W'(10));
    settings.insert(settings.size(), MAXD_W'($urandom_range(1, 255)));

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) offer(directed[i]);
    repeat (RANDOM_PER_PHASE) offer(random_req());
    settle();

    foreach (settings[s]) begin
      write_max_cells(settings[s]);
      if (s == 2) begin
        offer(pos_req(20, 1, 700, 700, 700, 700, 0, 1));
        offer(pos_req(21, 1, 700, 700, 701, 700, 0, 1));
      end
      repeat (RANDOM_PER_PHASE) offer(random_req());
      settle();
    end

    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
